// File: rtl/apt_pkg.sv
package apt_pkg;

  localparam int SLOTS     = 16;
  localparam int SLOT_BITS = $clog2(SLOTS);
  localparam int OFF_BITS  = 24;
  localparam int HND_BITS  = 32;
  localparam int REQ_BITS  = 3;
  localparam int STAT_BITS = 2;

  localparam logic [REQ_BITS-1:0] REQ_CREATE  = 3'd0;
  localparam logic [REQ_BITS-1:0] REQ_RESOLVE = 3'd1;
  localparam logic [REQ_BITS-1:0] REQ_RELEASE = 3'd2;
  localparam logic [REQ_BITS-1:0] REQ_EDIT    = 3'd3;
  localparam logic [REQ_BITS-1:0] REQ_CLEAR   = 3'd4;

  localparam logic [STAT_BITS-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_BITS-1:0] STAT_FULL = 2'd1;
  localparam logic [STAT_BITS-1:0] STAT_MISS = 2'd2;

  typedef struct packed {
    logic [HND_BITS-1:0] handle;
    logic [OFF_BITS-1:0] offset;
    logic                bias;
  } slot_entry_t;

  // sequencer -> slot store
  typedef struct packed {
    logic                 rd_en;
    logic [SLOT_BITS-1:0] rd_addr;
    logic                 wr_en;
    logic [SLOT_BITS-1:0] wr_addr;
    slot_entry_t          wr_data;
    logic                 set_valid;  // mark wr_addr valid
    logic                 clr_valid;
    logic [SLOT_BITS-1:0] clr_addr;
    logic                 clr_all;
  } store_cmd_t;

endpackage

// File: rtl/anchor_position_tracker.sv
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tuser: req_type; s_tdata: edit/anchor fields
// m_*       out  m_tvalid/m_tready  m_tdata: status, new_handle, position
//
// Create, clear and unused codes go from exec straight to finish, where the result is loaded.
// Resolve, release and edit walk all 16 slots through the slot RAM read port before m_tvalid
// rises: exec, one read per slot, the read latency, close, finish.
// Reset clears the slot valid bits and sets the handle counter to one.
// One request is in work at a time; a new request is taken while the previous
// result still waits, and a finished result holds until m_tready frees it.
module anchor_position_tracker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [23:0] offset, [47:24] removed_length, [71:48] inserted_length,
  // [72] bias, [104:73] handle, [111:105] zero
  input  logic [111:0] s_tdata,
  // [2:0] req_type
  input  logic [2:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [1:0] status, [33:2] new_handle, [57:34] position, [63:58] zero
  output logic [63:0]  m_tdata
);

  localparam int SB = apt_pkg::SLOT_BITS;
  localparam int OB = apt_pkg::OFF_BITS;
  localparam int HB = apt_pkg::HND_BITS;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_WALK = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t state, state_next;

  // latched request
  logic [apt_pkg::REQ_BITS-1:0] req_type;
  logic [OB-1:0]                req_off;
  logic [OB-1:0]                req_rem;
  logic [OB-1:0]                req_ins;
  logic                         req_bias;
  logic [HB-1:0]                req_handle;

  logic [HB-1:0] next_handle, next_handle_next;
  logic [SB:0]   iss_cnt, iss_cnt_next;   // reads issued so far, up to SLOTS
  logic          rd_pend, rd_pend_next;   // RAM data for rd_idx arrives now
  logic [SB-1:0] rd_idx;
  logic          found, found_next;
  logic [SB-1:0] hit_idx, hit_idx_next;
  logic [OB-1:0] hit_pos, hit_pos_next;

  logic [apt_pkg::STAT_BITS-1:0] res_status, res_status_next;
  logic [HB-1:0]                 res_nh, res_nh_next;
  logic [OB-1:0]                 res_pos, res_pos_next;
  logic                          load_out;

  apt_pkg::store_cmd_t       cmd;
  apt_pkg::slot_entry_t      rd_data;
  logic [apt_pkg::SLOTS-1:0] valid;
  logic                      free_found;
  logic [SB-1:0]             free_idx;
  logic [OB-1:0]             edit_off;
  logic                      accept;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  apt_slot_store u_store (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .rd_data    (rd_data),
    .valid      (valid),
    .free_found (free_found),
    .free_idx   (free_idx)
  );

  apt_edit_unit u_edit (
    .anchor_off  (rd_data.offset),
    .anchor_bias (rd_data.bias),
    .start       (req_off),
    .rem         (req_rem),
    .ins         (req_ins),
    .new_off     (edit_off)
  );

  always_comb begin
    state_next       = state;
    iss_cnt_next     = iss_cnt;
    rd_pend_next     = 1'b0;
    found_next       = found;
    hit_idx_next     = hit_idx;
    hit_pos_next     = hit_pos;
    next_handle_next = next_handle;
    res_status_next  = res_status;
    res_nh_next      = res_nh;
    res_pos_next     = res_pos;
    load_out         = 1'b0;
    cmd              = '0;

    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next   = ST_EXEC;
          iss_cnt_next = '0;
          found_next   = 1'b0;
        end
      end
      ST_EXEC: begin
        res_status_next = apt_pkg::STAT_OK;
        res_nh_next     = '0;
        res_pos_next    = '0;
        state_next      = ST_FIN;
        case (req_type) inside
          apt_pkg::REQ_CREATE: begin
            if (free_found) begin
              cmd.wr_en          = 1'b1;
              cmd.wr_addr        = free_idx;
              cmd.wr_data.handle = next_handle;
              cmd.wr_data.offset = req_off;
              cmd.wr_data.bias   = req_bias;
              cmd.set_valid      = 1'b1;
              res_nh_next        = next_handle;
              next_handle_next   = next_handle + HB'(1);
            end else begin
              res_status_next = apt_pkg::STAT_FULL;
            end
          end
          apt_pkg::REQ_RESOLVE, apt_pkg::REQ_RELEASE, apt_pkg::REQ_EDIT: begin
            state_next = ST_WALK;
          end
          apt_pkg::REQ_CLEAR: begin
            cmd.clr_all = 1'b1;
          end
          default: ;
        endcase
      end
      ST_WALK: begin
        // issue side: one slot read per cycle
        if (iss_cnt != (SB+1)'(apt_pkg::SLOTS)) begin
          cmd.rd_en    = 1'b1;
          cmd.rd_addr  = iss_cnt[SB-1:0];
          iss_cnt_next = iss_cnt + (SB+1)'(1);
          rd_pend_next = 1'b1;
        end
        // return side: entry of rd_idx is on rd_data
        if (rd_pend && valid[rd_idx]) begin
          if (req_type == apt_pkg::REQ_EDIT) begin
            cmd.wr_en          = 1'b1;
            cmd.wr_addr        = rd_idx;
            cmd.wr_data.handle = rd_data.handle;
            cmd.wr_data.offset = edit_off;
            cmd.wr_data.bias   = rd_data.bias;
          end else if (!found && rd_data.handle == req_handle) begin
            found_next   = 1'b1;
            hit_idx_next = rd_idx;
            hit_pos_next = rd_data.offset;
          end
        end
        if (iss_cnt == (SB+1)'(apt_pkg::SLOTS) && !rd_pend) begin
          state_next = ST_FIN;
          if (req_type != apt_pkg::REQ_EDIT) begin
            if (!found) begin
              res_status_next = apt_pkg::STAT_MISS;
            end else if (req_type == apt_pkg::REQ_RELEASE) begin
              cmd.clr_valid = 1'b1;
              cmd.clr_addr  = hit_idx;
            end else begin
              res_pos_next = hit_pos;
            end
          end
        end
      end
      ST_FIN: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      next_handle <= HB'(1);
      m_tvalid    <= 1'b0;
      rd_pend     <= 1'b0;
      found       <= 1'b0;
      iss_cnt     <= '0;
    end else begin
      state       <= state_next;
      next_handle <= next_handle_next;
      rd_pend     <= rd_pend_next;
      found       <= found_next;
      iss_cnt     <= iss_cnt_next;
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_type   <= s_tuser;
      req_off    <= s_tdata[23:0];
      req_rem    <= s_tdata[47:24];
      req_ins    <= s_tdata[71:48];
      req_bias   <= s_tdata[72];
      req_handle <= s_tdata[104:73];
    end
    rd_idx     <= cmd.rd_addr;
    hit_idx    <= hit_idx_next;
    hit_pos    <= hit_pos_next;
    res_status <= res_status_next;
    res_nh     <= res_nh_next;
    res_pos    <= res_pos_next;
    if (load_out) begin
      m_tdata <= {6'b0, res_pos, res_nh, res_status};
    end
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_EXEC)
    else $error("accepted request did not start");

  a_pend_in_walk: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> state == ST_WALK)
    else $error("slot read returned outside walk");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    load_out |=> m_tvalid && state == ST_IDLE)
    else $error("result load lost");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    state == ST_WALK |-> iss_cnt <= (SB+1)'(apt_pkg::SLOTS))
    else $error("walk counter overran");

endmodule

// File: rtl/apt_slot_store.sv
module apt_slot_store (
  input  logic                          clk,
  input  logic                          rst,
  input  apt_pkg::store_cmd_t           cmd,
  output apt_pkg::slot_entry_t          rd_data,
  output logic [apt_pkg::SLOTS-1:0]     valid,
  output logic                          free_found,
  output logic [apt_pkg::SLOT_BITS-1:0] free_idx
);

  apt_pkg::slot_entry_t mem [apt_pkg::SLOTS];

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= cmd.wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.clr_all) begin
      valid <= '0;
    end else begin
      if (cmd.set_valid) begin
        valid[cmd.wr_addr] <= 1'b1;
      end
      if (cmd.clr_valid) begin
        valid[cmd.clr_addr] <= 1'b0;
      end
    end
  end

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = apt_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_found = 1'b1;
        free_idx   = apt_pkg::SLOT_BITS'(i);
      end
    end
  end

endmodule

// File: rtl/apt_edit_unit.sv
module apt_edit_unit (
  input  logic [apt_pkg::OFF_BITS-1:0] anchor_off,
  input  logic                         anchor_bias,
  input  logic [apt_pkg::OFF_BITS-1:0] start,
  input  logic [apt_pkg::OFF_BITS-1:0] rem,
  input  logic [apt_pkg::OFF_BITS-1:0] ins,
  output logic [apt_pkg::OFF_BITS-1:0] new_off
);

  localparam int W = apt_pkg::OFF_BITS;

  logic [W:0]   end_pos;
  logic [W:0]   ins_sum;
  logic [W-1:0] ins_end;
  logic [W:0]   shifted;

  assign end_pos = {1'b0, start} + {1'b0, rem};
  assign ins_sum = {1'b0, start} + {1'b0, ins};
  assign ins_end = ins_sum[W] ? {W{1'b1}} : ins_sum[W-1:0];
  // anchor >= end >= rem here, so the subtract cannot wrap
  assign shifted = {1'b0, anchor_off - rem} + {1'b0, ins};

  always_comb begin
    if (anchor_off <= start) begin
      new_off = anchor_off;
    end else if ({1'b0, anchor_off} >= end_pos) begin
      new_off = shifted[W] ? {W{1'b1}} : shifted[W-1:0];
    end else begin
      new_off = anchor_bias ? ins_end : start;
    end
  end

endmodule
